>>> rtl/core/mfuw_pkg.sv
// ----------------------------------------------------------------------------
// mfuw_pkg
// widths, register indexes and request codes shared by the encoder unwrap
// core and its checker
// ----------------------------------------------------------------------------
package mfuw_pkg;

   localparam int POS_W       = 13;
   localparam int COUNTS_PER_TURN = 1 << POS_W;
   localparam int TURN_W      = 32;
   localparam int OFFSET_W    = 24;
   localparam int AGAIN_W     = 40;
   localparam int SGAIN_W     = 32;
   localparam int TOTAL_W     = 48;
   localparam int SPEED_W     = 32;
   localparam int RPM_W       = 16;
   localparam int TORQUE_W    = 16;
   localparam int TEMP_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 40;

   localparam logic signed [POS_W:0] HALF_TURN = (POS_W + 1)'(COUNTS_PER_TURN / 2);

   localparam logic [AGAIN_W-1:0] ANGLE_GAIN_RESET = 40'd215910;
   localparam logic [SGAIN_W-1:0] SPEED_GAIN_RESET = 32'd449717;

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENCODER_OFFSET = 2'd0,
      CSR_ANGLE_GAIN     = 2'd1,
      CSR_SPEED_GAIN     = 2'd2
   } csr_index_type;

endpackage

>>> rtl/core/motor_feedback_unwrap_watchdog_core.sv
// pipeline: six register stages from the accepting edge to rsp_valid (unwrap,
//    magnitude, partial products, two sum stages, result)
// throughput: one request per cycle; every stage advances whenever the stage
//    after it can, so only rsp_stall holds requests back
// reset: synchronous; clears turn count, position, watchdog flags and the
//    held results to zero and loads the default gains
// ----------------------------------------------------------------------------
// motor_feedback_unwrap_watchdog_core
// multi-turn encoder unwrap with fixed-point angle and speed scaling and an
// alive watchdog driven by tick requests
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_watchdog_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [mfuw_pkg::POS_W-1:0]            req_encoder_raw,
   input  logic signed [mfuw_pkg::RPM_W-1:0]     req_speed_rpm,
   input  logic signed [mfuw_pkg::TORQUE_W-1:0]  req_torque_raw,
   input  logic [mfuw_pkg::TEMP_W-1:0]           req_temperature,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mfuw_pkg::TOTAL_W-1:0]   rsp_total_count,
   output logic signed [mfuw_pkg::TOTAL_W-1:0]   rsp_angle_q16,
   output logic signed [mfuw_pkg::SPEED_W-1:0]   rsp_speed_q16,
   output logic signed [mfuw_pkg::TORQUE_W-1:0]  rsp_torque_out,
   output logic [mfuw_pkg::TEMP_W-1:0]           rsp_temperature_out,
   output logic                                  rsp_online,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mfuw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mfuw_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mfuw_pkg::*;

   // configuration
   logic [OFFSET_W-1:0] offset_ff;
   logic [AGAIN_W-1:0]  again_ff;
   logic [SGAIN_W-1:0]  sgain_ff;

   // front-end state
   logic [POS_W-1:0]    prev_pos_ff, prev_pos_in;
   logic [TURN_W-1:0]   turn_ff, turn_in;
   logic                frame_seen_ff, frame_seen_in;
   logic                online_flag_ff, online_flag_in;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
   logic accept, is_frame;
   logic frame1_ff, frame2_ff, frame3_ff, frame4_ff, frame5_ff;
   logic online1_ff, online2_ff, online3_ff, online4_ff, online5_ff;
   logic online1_in;

   // stage 1
   logic signed [POS_W:0] delta;
   logic [TOTAL_W-1:0]  total1_ff, total1_in;
   logic [RPM_W-1:0]    rpm1_ff;
   logic [TORQUE_W-1:0] torque1_ff, torque2_ff, torque3_ff, torque4_ff, torque5_ff;
   logic [TEMP_W-1:0]   temp1_ff, temp2_ff, temp3_ff, temp4_ff, temp5_ff;

   // stage 2
   logic [TOTAL_W-1:0]  total2_ff, total3_ff, total4_ff, total5_ff;
   logic                aneg2_ff, aneg3_ff, aneg4_ff, aneg5_ff;
   logic                sneg2_ff, sneg3_ff, sneg4_ff, sneg5_ff;
   logic [TOTAL_W-1:0]  amag2_ff, amag2_in;
   logic [RPM_W-1:0]    smag2_ff, smag2_in;

   // stage 3
   logic [63:0]         p00_3_ff, p00_3_in;
   logic [39:0]         p01_3_ff, p01_3_in;
   logic [47:0]         p10_3_ff, p10_3_in;
   logic [23:0]         p11_3_ff, p11_3_in;
   logic [47:0]         sprod3_ff, sprod3_in;

   // stage 4
   logic [64:0]         low_sum;
   logic [32:0]         lowr4_ff, lowr4_in;
   logic [48:0]         mid4_ff, mid4_in;
   logic [23:0]         p11_4_ff;
   logic [47:0]         sprod4_ff;

   // stage 5
   logic [56:0]         q5_ff, q5_in;
   logic [48:0]         s_sum;
   logic [32:0]         sq5_ff, sq5_in;

   // stage 6 (result register)
   logic [TOTAL_W-1:0]  total6_ff;
   logic [TOTAL_W-1:0]  angle6_ff, angle6_in, aclamp;
   logic [SPEED_W-1:0]  speed6_ff, speed6_in;
   logic [32:0]         sclamp;
   logic [TORQUE_W-1:0] torque6_ff;
   logic [TEMP_W-1:0]   temp6_ff;
   logic                online6_ff;

   // handshake
   assign rdy6      = !v6_ff || !rsp_stall;
   assign rdy5      = !v5_ff || rdy6;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign accept    = req_valid && rdy1;
   assign is_frame  = (req_opcode == OP_FRAME);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         again_ff  <= ANGLE_GAIN_RESET;
         sgain_ff  <= SPEED_GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENCODER_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_ANGLE_GAIN:     again_ff  <= csr_wdata[AGAIN_W-1:0];
            CSR_SPEED_GAIN:     sgain_ff  <= csr_wdata[SGAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // unwrap and watchdog
   assign delta = $signed({1'b0, req_encoder_raw}) - $signed({1'b0, prev_pos_ff});

   always_comb begin
      prev_pos_in    = prev_pos_ff;
      turn_in        = turn_ff;
      frame_seen_in  = frame_seen_ff;
      online_flag_in = online_flag_ff;
      if (is_frame) begin
         prev_pos_in   = req_encoder_raw;
         frame_seen_in = 1'b1;
         priority if (delta < -HALF_TURN) begin
            turn_in = turn_ff + 1'b1;
         end else if (delta > HALF_TURN) begin
            turn_in = turn_ff - 1'b1;
         end else begin
            turn_in = turn_ff;
         end
      end else begin
         online_flag_in = frame_seen_ff;
         frame_seen_in  = 1'b0;
      end
   end

   assign online1_in = is_frame ? online_flag_ff : frame_seen_ff;
   assign total1_in  = {{(TOTAL_W - TURN_W - POS_W){turn_in[TURN_W-1]}}, turn_in,
                        req_encoder_raw}
                     + {{(TOTAL_W - OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff    <= '0;
         turn_ff        <= '0;
         frame_seen_ff  <= 1'b0;
         online_flag_ff <= 1'b0;
      end else if (accept) begin
         prev_pos_ff    <= prev_pos_in;
         turn_ff        <= turn_in;
         frame_seen_ff  <= frame_seen_in;
         online_flag_ff <= online_flag_in;
      end
   end

   // datapath
   assign amag2_in  = total1_ff[TOTAL_W-1] ? (TOTAL_W)'(~total1_ff + 1'b1) : total1_ff;
   assign smag2_in  = rpm1_ff[RPM_W-1] ? (RPM_W)'(~rpm1_ff + 1'b1) : rpm1_ff;

   assign p00_3_in  = amag2_ff[31:0] * again_ff[31:0];
   assign p01_3_in  = amag2_ff[31:0] * again_ff[39:32];
   assign p10_3_in  = amag2_ff[47:32] * again_ff[31:0];
   assign p11_3_in  = amag2_ff[47:32] * again_ff[39:32];
   assign sprod3_in = smag2_ff * sgain_ff;

   assign low_sum   = {1'b0, p00_3_ff} + 65'h0_8000_0000;
   assign lowr4_in  = low_sum[64:32];
   assign mid4_in   = 49'(p01_3_ff) + 49'(p10_3_ff);

   assign q5_in     = 57'(lowr4_ff) + 57'(mid4_ff) + 57'({p11_4_ff, 32'd0});
   assign s_sum     = 49'(sprod4_ff) + 49'h8000;
   assign sq5_in    = s_sum[48:16];

   // round-to-nearest results, saturated and signed
   always_comb begin
      if (aneg5_ff) begin
         aclamp    = (q5_ff > 57'h0_8000_0000_0000) ? 48'h8000_0000_0000 : q5_ff[47:0];
         angle6_in = (TOTAL_W)'(~aclamp + 1'b1);
      end else begin
         aclamp    = (q5_ff > 57'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q5_ff[47:0];
         angle6_in = aclamp;
      end
      if (sneg5_ff) begin
         sclamp    = (sq5_ff > 33'h0_8000_0000) ? 33'h0_8000_0000 : sq5_ff;
         speed6_in = (SPEED_W)'(~sclamp[31:0] + 1'b1);
      end else begin
         sclamp    = (sq5_ff > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : sq5_ff;
         speed6_in = sclamp[31:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (rdy1) begin
         frame1_ff  <= is_frame;
         online1_ff <= online1_in;
         total1_ff  <= total1_in;
         rpm1_ff    <= req_speed_rpm;
         torque1_ff <= req_torque_raw;
         temp1_ff   <= req_temperature;
      end
      if (rdy2) begin
         frame2_ff  <= frame1_ff;
         online2_ff <= online1_ff;
         total2_ff  <= total1_ff;
         aneg2_ff   <= total1_ff[TOTAL_W-1];
         sneg2_ff   <= rpm1_ff[RPM_W-1];
         amag2_ff   <= amag2_in;
         smag2_ff   <= smag2_in;
         torque2_ff <= torque1_ff;
         temp2_ff   <= temp1_ff;
      end
      if (rdy3) begin
         frame3_ff  <= frame2_ff;
         online3_ff <= online2_ff;
         total3_ff  <= total2_ff;
         aneg3_ff   <= aneg2_ff;
         sneg3_ff   <= sneg2_ff;
         p00_3_ff   <= p00_3_in;
         p01_3_ff   <= p01_3_in;
         p10_3_ff   <= p10_3_in;
         p11_3_ff   <= p11_3_in;
         sprod3_ff  <= sprod3_in;
         torque3_ff <= torque2_ff;
         temp3_ff   <= temp2_ff;
      end
      if (rdy4) begin
         frame4_ff  <= frame3_ff;
         online4_ff <= online3_ff;
         total4_ff  <= total3_ff;
         aneg4_ff   <= aneg3_ff;
         sneg4_ff   <= sneg3_ff;
         lowr4_ff   <= lowr4_in;
         mid4_ff    <= mid4_in;
         p11_4_ff   <= p11_3_ff;
         sprod4_ff  <= sprod3_ff;
         torque4_ff <= torque3_ff;
         temp4_ff   <= temp3_ff;
      end
      if (rdy5) begin
         frame5_ff  <= frame4_ff;
         online5_ff <= online4_ff;
         total5_ff  <= total4_ff;
         aneg5_ff   <= aneg4_ff;
         sneg5_ff   <= sneg4_ff;
         q5_ff      <= q5_in;
         sq5_ff     <= sq5_in;
         torque5_ff <= torque4_ff;
         temp5_ff   <= temp4_ff;
      end
   end

   // result register; frame values are held for tick results
   always_ff @(posedge clock) begin
      if (reset) begin
         total6_ff  <= '0;
         angle6_ff  <= '0;
         speed6_ff  <= '0;
         torque6_ff <= '0;
         temp6_ff   <= '0;
         online6_ff <= 1'b0;
      end else if (rdy6 && v5_ff) begin
         online6_ff <= online5_ff;
         if (frame5_ff) begin
            total6_ff  <= total5_ff;
            angle6_ff  <= angle6_in;
            speed6_ff  <= speed6_in;
            torque6_ff <= torque5_ff;
            temp6_ff   <= temp5_ff;
         end
      end
   end

   assign rsp_valid           = v6_ff;
   assign rsp_total_count     = total6_ff;
   assign rsp_angle_q16       = angle6_ff;
   assign rsp_speed_q16       = speed6_ff;
   assign rsp_torque_out      = torque6_ff;
   assign rsp_temperature_out = temp6_ff;
   assign rsp_online          = online6_ff;

endmodule

>>> rtl/core/mfuw_checker.sv
// ----------------------------------------------------------------------------
// mfuw_checker
// port-level checks for the encoder unwrap core, bound to the top level
// ----------------------------------------------------------------------------
module mfuw_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [mfuw_pkg::TOTAL_W-1:0]   rsp_total_count,
   input logic signed [mfuw_pkg::TOTAL_W-1:0]   rsp_angle_q16,
   input logic signed [mfuw_pkg::SPEED_W-1:0]   rsp_speed_q16,
   input logic signed [mfuw_pkg::TORQUE_W-1:0]  rsp_torque_out,
   input logic [mfuw_pkg::TEMP_W-1:0]           rsp_temperature_out,
   input logic                                  rsp_online,
   input logic                                  csr_valid,
   input logic                                  csr_ready
);
   import mfuw_pkg::*;

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_count)
         && $stable(rsp_angle_q16) && $stable(rsp_speed_q16) && $stable(rsp_online)
         && $stable(rsp_torque_out) && $stable(rsp_temperature_out))
      else $error("stalled response changed");

   // negative angle only from a negative total
   a_angle_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_angle_q16[TOTAL_W-1] && !rsp_total_count[TOTAL_W-1]))
      else $error("angle sign disagrees with total count");

   // register port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write blocked");

endmodule

bind motor_feedback_unwrap_watchdog_core mfuw_checker u_mfuw_checker (.*);

>>> tb/sv/motor_feedback_unwrap_watchdog_core_tb.sv
// ----------------------------------------------------------------------------
// motor_feedback_unwrap_watchdog_core_tb
// drives feedback frame and alive tick requests into the encoder unwrap core,
// predicts each response from the unwrap, gain scaling and watchdog rules and
// compares it field by field; covers reset defaults, half-turn boundaries,
// extreme and random register settings, bursty requests and receiver stalls
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_watchdog_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfuw_pkg::*;

   localparam int LONG_HOLD     = 80;
   localparam int PHASE_ITEMS   = 150;
   localparam int PHASE_COUNT   = 6;
   localparam int DRAIN_CYCLES  = 12;

   typedef struct packed {
      logic [TOTAL_W-1:0]  total;
      logic [TOTAL_W-1:0]  angle;
      logic [SPEED_W-1:0]  speed;
      logic [TORQUE_W-1:0] torque;
      logic [TEMP_W-1:0]   temp;
      logic                online;
   } feedback_type;

   typedef struct packed {
      op_type              op;
      logic [POS_W-1:0]    raw;
      logic [RPM_W-1:0]    rpm;
      logic [TORQUE_W-1:0] torque;
      logic [TEMP_W-1:0]   temp;
      logic                typed;
      feedback_type        want;
   } stim_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_opcode;
   logic [POS_W-1:0]            req_encoder_raw;
   logic signed [RPM_W-1:0]     req_speed_rpm;
   logic signed [TORQUE_W-1:0]  req_torque_raw;
   logic [TEMP_W-1:0]           req_temperature;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [TOTAL_W-1:0]   rsp_total_count;
   logic signed [TOTAL_W-1:0]   rsp_angle_q16;
   logic signed [SPEED_W-1:0]   rsp_speed_q16;
   logic signed [TORQUE_W-1:0]  rsp_torque_out;
   logic [TEMP_W-1:0]           rsp_temperature_out;
   logic                        rsp_online;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   // travels with the request payload
   logic                        row_typed;
   feedback_type                row_want;

   // predicted block state and registers
   logic [POS_W-1:0]            prev_pos;
   logic [TURN_W-1:0]           turns;
   logic                        frame_seen;
   logic                        online_flag;
   feedback_type                held;
   logic [OFFSET_W-1:0]         offset_reg;
   logic [AGAIN_W-1:0]          angle_gain_reg;
   logic [SGAIN_W-1:0]          speed_gain_reg;

   feedback_type                pending_feedback_q[$];
   int                          mismatch_count;
   int                          burst_left;
   bit                          hold_off_pending;

   stim_row_type directed_rows [0:17] = '{
      '{OP_TICK,  13'h1555, 16'h7FFF, 16'h1234, 8'hAA, 1'b1,
        '{48'd0, 48'd0, 32'd0, 16'd0, 8'd0, 1'b0}},
      '{OP_FRAME, 13'h1FFF, 16'h0000, 16'h8000, 8'hFF, 1'b1,
        '{48'hFFFF_FFFF_FFFF, 48'd0, 32'd0, 16'h8000, 8'hFF, 1'b0}},
      '{OP_TICK,  13'h0AAA, 16'h8000, 16'h5A5A, 8'h55, 1'b1,
        '{48'hFFFF_FFFF_FFFF, 48'd0, 32'd0, 16'h8000, 8'hFF, 1'b1}},
      '{OP_TICK,  13'h1FFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1,
        '{48'hFFFF_FFFF_FFFF, 48'd0, 32'd0, 16'h8000, 8'hFF, 1'b0}},
      '{OP_FRAME, 13'h0000, 16'h7FFF, 16'h7FFF, 8'h00, 1'b0, '0},
      '{OP_FRAME, 13'h1000, 16'h8000, 16'h0001, 8'h01, 1'b0, '0},
      '{OP_FRAME, 13'h0000, 16'hFFFF, 16'hFFFE, 8'h80, 1'b0, '0},
      '{OP_FRAME, 13'h1001, 16'h0001, 16'h0000, 8'h7F, 1'b0, '0},
      '{OP_FRAME, 13'h0000, 16'h0064, 16'hFF9C, 8'h40, 1'b0, '0},
      '{OP_FRAME, 13'h1FFF, 16'hF000, 16'h0FFF, 8'h20, 1'b0, '0},
      '{OP_FRAME, 13'h0FFF, 16'h0FFF, 16'hF000, 8'h10, 1'b0, '0},
      '{OP_FRAME, 13'h1FFF, 16'h5555, 16'hAAAA, 8'h08, 1'b0, '0},
      '{OP_FRAME, 13'h0003, 16'hAAAA, 16'h5555, 8'h04, 1'b0, '0},
      '{OP_TICK,  13'h0123, 16'h1234, 16'h4321, 8'h99, 1'b0, '0},
      '{OP_FRAME, 13'h1770, 16'h8000, 16'h0000, 8'h80, 1'b0, '0},
      '{OP_TICK,  13'h1ABC, 16'h0000, 16'h8000, 8'hFF, 1'b0, '0},
      '{OP_TICK,  13'h0000, 16'h7FFF, 16'h7FFF, 8'h00, 1'b0, '0},
      '{OP_FRAME, 13'h0800, 16'hC000, 16'h4000, 8'h3C, 1'b0, '0}
   };

   motor_feedback_unwrap_watchdog_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [TOTAL_W-1:0] scale_angle(logic [TOTAL_W-1:0] total);
      logic [TOTAL_W-1:0] mag;
      logic [95:0]        q;
      mag = total[TOTAL_W-1] ? ~total + 48'd1 : total;
      q = ({48'd0, mag} * {56'd0, angle_gain_reg} + 96'h8000_0000) >> 32;
      if (total[TOTAL_W-1]) begin
         if (q > 96'h8000_0000_0000) q = 96'h8000_0000_0000;
         return ~q[TOTAL_W-1:0] + 48'd1;
      end
      if (q > 96'h7FFF_FFFF_FFFF) q = 96'h7FFF_FFFF_FFFF;
      return q[TOTAL_W-1:0];
   endfunction

   function automatic logic [SPEED_W-1:0] scale_speed(logic [RPM_W-1:0] rpm);
      logic [RPM_W-1:0] mag;
      logic [63:0]      q;
      mag = rpm[RPM_W-1] ? ~rpm + 16'd1 : rpm;
      q = ({48'd0, mag} * {32'd0, speed_gain_reg} + 64'h8000) >> 16;
      if (rpm[RPM_W-1]) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return ~q[SPEED_W-1:0] + 32'd1;
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[SPEED_W-1:0];
   endfunction

   function automatic feedback_type unwrap_feedback(op_type op, logic [POS_W-1:0] raw,
                                                    logic [RPM_W-1:0] rpm,
                                                    logic [TORQUE_W-1:0] torque,
                                                    logic [TEMP_W-1:0] temp);
      int                 delta;
      logic [TOTAL_W-1:0] total;
      feedback_type       res;
      if (op == OP_FRAME) begin
         delta = int'(raw) - int'(prev_pos);
         if (delta < -(COUNTS_PER_TURN / 2)) turns = turns + 1'b1;
         else if (delta > COUNTS_PER_TURN / 2) turns = turns - 1'b1;
         prev_pos = raw;
         total = {{(TOTAL_W-TURN_W){turns[TURN_W-1]}}, turns} * TOTAL_W'(COUNTS_PER_TURN)
               + TOTAL_W'(raw) + {{(TOTAL_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
         held.total  = total;
         held.angle  = scale_angle(total);
         held.speed  = scale_speed(rpm);
         held.torque = torque;
         held.temp   = temp;
         frame_seen  = 1'b1;
      end else begin
         online_flag = frame_seen;
         frame_seen  = 1'b0;
      end
      res = held;
      res.online = online_flag;
      return res;
   endfunction

   function automatic void compare_field(string name, logic [TOTAL_W-1:0] want,
                                         logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      feedback_type want;
      feedback_type got;
      if (reset) begin
         prev_pos       = '0;
         turns          = '0;
         frame_seen     = 1'b0;
         online_flag    = 1'b0;
         held           = '0;
         offset_reg     = '0;
         angle_gain_reg = ANGLE_GAIN_RESET;
         speed_gain_reg = SPEED_GAIN_RESET;
         pending_feedback_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENCODER_OFFSET: offset_reg     = csr_wdata[OFFSET_W-1:0];
               CSR_ANGLE_GAIN:     angle_gain_reg = csr_wdata[AGAIN_W-1:0];
               CSR_SPEED_GAIN:     speed_gain_reg = csr_wdata[SGAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = unwrap_feedback(op_type'(req_opcode), req_encoder_raw, req_speed_rpm,
                                   req_torque_raw, req_temperature);
            if (row_typed) want = row_want;
            pending_feedback_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_total_count, rsp_angle_q16, rsp_speed_q16, rsp_torque_out,
                    rsp_temperature_out, rsp_online};
            if (pending_feedback_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual total %0h",
                        $time, got.total);
               mismatch_count++;
            end else begin
               want = pending_feedback_q.pop_front();
               compare_field("total_count", want.total, got.total);
               compare_field("angle_q16", want.angle, got.angle);
               compare_field("speed_q16", want.speed, got.speed);
               compare_field("torque_out", want.torque, got.torque);
               compare_field("temperature_out", want.temp, got.temp);
               compare_field("online", want.online, got.online);
            end
         end
      end
   end

   // receiver stalls in segments of random density, plus one long hold-off
   initial begin : receiver
      int run_len;
      int stall_pct;
      rsp_stall <= 1'b0;
      forever begin
         run_len   = $urandom_range(8, 64);
         stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
         repeat (run_len) begin
            @(posedge clock);
            if (hold_off_pending) begin
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD) @(posedge clock);
               hold_off_pending = 1'b0;
            end
            rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
         end
      end
   end

   task automatic send_feedback(input op_type op, input logic [POS_W-1:0] raw,
                                input logic [RPM_W-1:0] rpm, input logic [TORQUE_W-1:0] torque,
                                input logic [TEMP_W-1:0] temp, input logic typed,
                                input feedback_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_encoder_raw <= raw;
      req_speed_rpm   <= rpm;
      req_torque_raw  <= torque;
      req_temperature <= temp;
      row_typed       <= typed;
      row_want        <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_feedback_q.size() != 0);
   endtask

   task automatic load_settings(input logic [OFFSET_W-1:0] offset,
                                input logic [AGAIN_W-1:0] again,
                                input logic [SGAIN_W-1:0] sgain);
      csr_valid <= 1'b1;
      csr_index <= CSR_ENCODER_OFFSET;
      csr_wdata <= {{(CSR_DATA_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ANGLE_GAIN;
      csr_wdata <= again;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_SPEED_GAIN;
      csr_wdata <= {{(CSR_DATA_W-SGAIN_W){1'b0}}, sgain};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      #4ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int               step;
      int               drift;
      int               kind;
      logic [POS_W-1:0] pos;
      logic [RPM_W-1:0] rpm;
      logic [63:0]      wide;
      mismatch_count   = 0;
      burst_left       = 0;
      hold_off_pending = 1'b0;
      pos              = '0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_FRAME;
      req_encoder_raw <= '0;
      req_speed_rpm   <= '0;
      req_torque_raw  <= '0;
      req_temperature <= '0;
      row_typed       <= 1'b0;
      row_want        <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_ENCODER_OFFSET;
      csr_wdata       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, first frame past half a turn, watchdog, turn boundaries
      foreach (directed_rows[i])
         send_feedback(directed_rows[i].op, directed_rows[i].raw, directed_rows[i].rpm,
                       directed_rows[i].torque, directed_rows[i].temp,
                       directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: load_settings(24'h7F_FFFF, '1, '1);
            1: begin
               load_settings(24'h80_0000, '0, '0);
               hold_off_pending = 1'b1;
            end
            2: load_settings('0, ANGLE_GAIN_RESET, SPEED_GAIN_RESET);
            default: begin
               wide = {$urandom, $urandom};
               load_settings(OFFSET_W'($urandom), wide[AGAIN_W-1:0], $urandom);
            end
         endcase
         drift = int'($urandom_range(0, 600)) - 300;
         repeat (PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            rpm = ($urandom_range(0, 3) == 0) ? RPM_W'($urandom)
                                               : RPM_W'(int'($urandom_range(0, 4000)) - 2000);
            if (kind < 15) begin
               send_feedback(OP_TICK, POS_W'($urandom), rpm, TORQUE_W'($urandom),
                             TEMP_W'($urandom), 1'b0, '0);
            end else begin
               if (kind < 25) begin
                  pos = POS_W'($urandom);
               end else if (kind < 37) begin
                  // jumps right around half a turn
                  step = int'($urandom_range(4094, 4098));
                  if ($urandom_range(0, 1) == 1) step = -step;
                  pos = POS_W'(int'(pos) + step);
               end else begin
                  pos = POS_W'(int'(pos) + drift + int'($urandom_range(0, 200)) - 100);
               end
               send_feedback(OP_FRAME, pos, rpm, TORQUE_W'($urandom), TEMP_W'($urandom),
                             1'b0, '0);
            end
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
